// ----- design/crc16_framed_packet_receiver_assert.svh -----
// assertion macros used by the checker
`ifndef CRC16_FRAMED_PACKET_RECEIVER_ASSERT_SVH
`define CRC16_FRAMED_PACKET_RECEIVER_ASSERT_SVH

// same-cycle implication under reset
`define CFPR_ASSERT_NOW(name, clk, rstn, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("cfpr assertion failed");

// next-cycle implication under reset
`define CFPR_ASSERT_NEXT(name, clk, rstn, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("cfpr assertion failed");

`endif

// ----- design/cfpr_pkg.sv -----
`timescale 1ns / 1ps

package cfpr_pkg;

	localparam int MAX_PAYLOAD_DEF = 64;
	localparam int HEADER_BYTES = 6;

	localparam logic [7:0] START_A = 8'hA5;
	localparam logic [7:0] START_B = 8'h5A;
	localparam logic [7:0] END_MARK = 8'h0D;
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [15:0] CRC_SEED = 16'hFFFF;

	localparam logic [7:0] VERSION_RESET = 8'd1;
	localparam logic [6:0] LIMIT_RESET = 7'd64;

	localparam logic REG_VERSION = 1'b0;
	localparam logic REG_LIMIT = 1'b1;

	localparam logic [1:0] ST_GOOD = 2'd0;
	localparam logic [1:0] ST_CRC = 2'd1;
	localparam logic [1:0] ST_BAD_END = 2'd2;
	localparam logic [1:0] ST_FORMAT = 2'd3;

	typedef struct packed {
		logic [7:0] expected_version;
		logic [6:0] length_limit;
	} cfpr_cfg_t;

	typedef struct packed {
		logic start;
		logic burst;
		logic [1:0] status;
		logic [7:0] kind;
		logic [15:0] seq;
		logic [6:0] len;
	} cfpr_done_t;

	function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'd0, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0])
				c = (c >> 1) ^ CRC_POLY;
			else
				c = c >> 1;
		end
		return c;
	endfunction

endpackage

// ----- design/cfpr_if.sv -----
`timescale 1ns / 1ps

interface cfpr_rx_if;
	logic valid;
	logic ready;
	logic [7:0] rx_data;
	modport source (output valid, output rx_data, input ready);
	modport sink (input valid, input rx_data, output ready);
endinterface

interface cfpr_res_if;
	logic valid;
	logic ready;
	logic [1:0] frame_status;
	logic [7:0] message_kind;
	logic [15:0] sequence_number;
	logic [6:0] frame_length;
	logic [5:0] byte_index;
	logic [7:0] payload_byte;
	logic has_payload;
	logic end_of_run;
	modport source (output valid, output frame_status, output message_kind,
		output sequence_number, output frame_length, output byte_index,
		output payload_byte, output has_payload, output end_of_run, input ready);
	modport sink (input valid, input frame_status, input message_kind,
		input sequence_number, input frame_length, input byte_index,
		input payload_byte, input has_payload, input end_of_run, output ready);
endinterface

interface cfpr_cfg_if;
	logic valid;
	logic ready;
	logic reg_index;
	logic [7:0] reg_data;
	modport source (output valid, output reg_index, output reg_data, input ready);
	modport sink (input valid, input reg_index, input reg_data, output ready);
endinterface

// ----- design/crc16_framed_packet_receiver.sv -----
`timescale 1ns / 1ps

// Frame receiver: takes one received byte per cycle on rx while ready, hunting for
// A5 5A, then a six-byte header, payload, CRC-16/MODBUS and end byte 0D. Payload bytes
// go into a one-port-read payload memory; after a good end byte and CRC they are read
// back and delivered one result per byte, each read through the memory's registered
// read port and then registered into the result; a stall on res holds the next read.
// A status result (crc mismatch, bad end byte, header format error or empty good frame)
// is a single result without payload. rx.ready is low while any result of the last
// frame is still pending. Configuration writes on cfg are always ready.
module crc16_framed_packet_receiver #(
	parameter int MAX_PAYLOAD = cfpr_pkg::MAX_PAYLOAD_DEF
) (
	input logic clk,
	input logic arst_n,
	cfpr_rx_if.sink rx,
	cfpr_res_if.source res,
	cfpr_cfg_if.sink cfg
);

	import cfpr_pkg::*;

	localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

	cfpr_cfg_t cfg_q;
	cfpr_done_t done;
	logic busy;
	logic mem_we;
	logic [AW-1:0] mem_waddr;
	logic [7:0] mem_wdata;
	logic mem_re;
	logic [AW-1:0] mem_raddr;
	logic [7:0] mem_rdata;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expected_version <= VERSION_RESET;
			cfg_q.length_limit <= LIMIT_RESET;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.reg_index)
				REG_VERSION: cfg_q.expected_version <= cfg.reg_data;
				REG_LIMIT: cfg_q.length_limit <= cfg.reg_data[6:0];
				default: ;
			endcase
		end
	end

	cfpr_parser #(.MAX_PAYLOAD(MAX_PAYLOAD), .AW(AW)) u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx),
		.cfg_regs(cfg_q),
		.busy(busy),
		.done(done),
		.mem_we(mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata)
	);

	cfpr_payload_ram #(.DEPTH(MAX_PAYLOAD), .AW(AW)) u_ram (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re(mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	cfpr_emitter #(.AW(AW)) u_emitter (
		.clk(clk),
		.arst_n(arst_n),
		.done(done),
		.busy(busy),
		.mem_re(mem_re),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata),
		.res(res)
	);

endmodule

// ----- design/cfpr_payload_ram.sv -----
`timescale 1ns / 1ps

module cfpr_payload_ram #(
	parameter int DEPTH = cfpr_pkg::MAX_PAYLOAD_DEF,
	parameter int AW = 6
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [7:0] wdata,
	input logic re,
	input logic [AW-1:0] raddr,
	output logic [7:0] rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem[raddr];
	end

endmodule

// ----- design/cfpr_parser.sv -----
`timescale 1ns / 1ps

module cfpr_parser #(
	parameter int MAX_PAYLOAD = cfpr_pkg::MAX_PAYLOAD_DEF,
	parameter int AW = 6
) (
	input logic clk,
	input logic arst_n,
	cfpr_rx_if.sink rx,
	input cfpr_pkg::cfpr_cfg_t cfg_regs,
	input logic busy,
	output cfpr_pkg::cfpr_done_t done,
	output logic mem_we,
	output logic [AW-1:0] mem_waddr,
	output logic [7:0] mem_wdata
);

	import cfpr_pkg::*;

	localparam logic [2:0] PH_SOF1 = 3'd0;
	localparam logic [2:0] PH_SOF2 = 3'd1;
	localparam logic [2:0] PH_HEADER = 3'd2;
	localparam logic [2:0] PH_PAYLOAD = 3'd3;
	localparam logic [2:0] PH_CRC_LO = 3'd4;
	localparam logic [2:0] PH_CRC_HI = 3'd5;
	localparam logic [2:0] PH_END = 3'd6;

	localparam logic [6:0] MAX_LEN = 7'(MAX_PAYLOAD);
	localparam logic [2:0] LAST_HDR = 3'(HEADER_BYTES - 1);

	logic [2:0] phase_q;
	logic [2:0] hcnt_q;
	logic [6:0] pcnt_q;
	logic [6:0] ptotal_q;
	logic [15:0] crc_q;
	logic [15:0] rcrc_q;
	logic [7:0] hdr0_q, hdr1_q, hdr2_q, hdr3_q, hdr4_q;

	logic fire;
	logic [7:0] b;
	logic [15:0] crc_next;
	logic [15:0] hlen;
	logic [6:0] limit;
	logic fmt_bad;
	logic [6:0] hlen_sat;
	logic [6:0] pcnt_inc;

	assign rx.ready = !busy;

	always_comb begin
		fire = rx.valid && rx.ready;
		b = rx.rx_data;
		crc_next = crc_feed(crc_q, b);
		hlen = {b, hdr4_q};
		limit = (cfg_regs.length_limit > MAX_LEN) ? MAX_LEN : cfg_regs.length_limit;
		fmt_bad = (hdr0_q != cfg_regs.expected_version) || (hlen > {9'd0, limit});
		hlen_sat = (hlen > 16'd127) ? 7'd127 : hlen[6:0];
		pcnt_inc = pcnt_q + 7'd1;
	end

	always_comb begin
		done = '0;
		done.kind = hdr1_q;
		done.seq = {hdr3_q, hdr2_q};
		done.len = ptotal_q;
		if (fire && phase_q == PH_HEADER && hcnt_q == LAST_HDR && fmt_bad) begin
			done.start = 1'b1;
			done.status = ST_FORMAT;
			done.len = hlen_sat;
		end else if (fire && phase_q == PH_END) begin
			done.start = 1'b1;
			if (b != END_MARK)
				done.status = ST_BAD_END;
			else if (crc_q != rcrc_q)
				done.status = ST_CRC;
			else begin
				done.status = ST_GOOD;
				done.burst = (ptotal_q != 7'd0);
			end
		end
	end

	assign mem_we = fire && (phase_q == PH_PAYLOAD);
	assign mem_waddr = pcnt_q[AW-1:0];
	assign mem_wdata = b;

	// header bytes
	always_ff @(posedge clk) begin
		if (fire && phase_q == PH_HEADER) begin
			case (hcnt_q)
				3'd0: hdr0_q <= b;
				3'd1: hdr1_q <= b;
				3'd2: hdr2_q <= b;
				3'd3: hdr3_q <= b;
				3'd4: hdr4_q <= b;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SOF1;
			hcnt_q <= '0;
			pcnt_q <= '0;
			ptotal_q <= '0;
			crc_q <= CRC_SEED;
			rcrc_q <= '0;
		end else if (fire) begin
			case (phase_q)
				PH_SOF1: begin
					if (b == START_A)
						phase_q <= PH_SOF2;
				end
				PH_SOF2: begin
					if (b == START_B) begin
						phase_q <= PH_HEADER;
						crc_q <= CRC_SEED;
					end else if (b != START_A) begin
						phase_q <= PH_SOF1;
					end
					hcnt_q <= '0;
				end
				PH_HEADER: begin
					hcnt_q <= hcnt_q + 3'd1;
					crc_q <= crc_next;
					if (hcnt_q == LAST_HDR) begin
						if (fmt_bad) begin
							phase_q <= PH_SOF1;
							hcnt_q <= '0;
							pcnt_q <= '0;
							ptotal_q <= '0;
							crc_q <= CRC_SEED;
							rcrc_q <= '0;
						end else begin
							ptotal_q <= hlen[6:0];
							pcnt_q <= '0;
							phase_q <= (hlen == 16'd0) ? PH_CRC_LO : PH_PAYLOAD;
						end
					end
				end
				PH_PAYLOAD: begin
					pcnt_q <= pcnt_inc;
					crc_q <= crc_next;
					if (pcnt_inc >= ptotal_q)
						phase_q <= PH_CRC_LO;
				end
				PH_CRC_LO: begin
					rcrc_q <= {8'd0, b};
					phase_q <= PH_CRC_HI;
				end
				PH_CRC_HI: begin
					rcrc_q <= {b, rcrc_q[7:0]};
					phase_q <= PH_END;
				end
				default: begin
					phase_q <= PH_SOF1;
					hcnt_q <= '0;
					pcnt_q <= '0;
					ptotal_q <= '0;
					crc_q <= CRC_SEED;
					rcrc_q <= '0;
				end
			endcase
		end
	end

endmodule

// ----- design/cfpr_emitter.sv -----
`timescale 1ns / 1ps

module cfpr_emitter #(
	parameter int AW = 6
) (
	input logic clk,
	input logic arst_n,
	input cfpr_pkg::cfpr_done_t done,
	output logic busy,
	output logic mem_re,
	output logic [AW-1:0] mem_raddr,
	input logic [7:0] mem_rdata,
	cfpr_res_if.source res
);

	import cfpr_pkg::*;

	logic out_valid_q;
	logic [1:0] status_q;
	logic [7:0] kind_q;
	logic [15:0] seq_q;
	logic [6:0] len_q;
	logic [5:0] idx_q;
	logic [7:0] byte_q;
	logic has_q;
	logic last_q;

	logic rd_active_q;
	logic rd_pend_q;
	logic [5:0] rd_idx_q;

	logic out_fire;
	logic issue;
	logic rd_last;

	always_comb begin
		out_fire = out_valid_q && res.ready;
		issue = rd_active_q && !rd_pend_q && (!out_valid_q || res.ready);
		rd_last = ({1'b0, rd_idx_q} + 7'd1) == len_q;
	end

	assign busy = rd_active_q || out_valid_q;
	assign mem_re = issue;
	assign mem_raddr = rd_idx_q[AW-1:0];

	assign res.valid = out_valid_q;
	assign res.frame_status = status_q;
	assign res.message_kind = kind_q;
	assign res.sequence_number = seq_q;
	assign res.frame_length = len_q;
	assign res.byte_index = idx_q;
	assign res.payload_byte = byte_q;
	assign res.has_payload = has_q;
	assign res.end_of_run = last_q;

	// result fields
	always_ff @(posedge clk) begin
		if (done.start) begin
			status_q <= done.status;
			kind_q <= done.kind;
			seq_q <= done.seq;
			len_q <= done.len;
			idx_q <= '0;
			byte_q <= '0;
			has_q <= 1'b0;
			last_q <= 1'b1;
		end else if (rd_pend_q) begin
			idx_q <= rd_idx_q;
			byte_q <= mem_rdata;
			has_q <= 1'b1;
			last_q <= rd_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			rd_active_q <= 1'b0;
			rd_pend_q <= 1'b0;
			rd_idx_q <= '0;
		end else begin
			if (out_fire)
				out_valid_q <= 1'b0;
			if (done.start) begin
				if (done.burst) begin
					rd_active_q <= 1'b1;
					rd_idx_q <= '0;
				end else begin
					out_valid_q <= 1'b1;
				end
			end else begin
				if (issue)
					rd_pend_q <= 1'b1;
				if (rd_pend_q) begin
					out_valid_q <= 1'b1;
					rd_pend_q <= 1'b0;
					rd_idx_q <= rd_idx_q + 6'd1;
					if (rd_last)
						rd_active_q <= 1'b0;
				end
			end
		end
	end

endmodule

// ----- design/cfpr_checker.sv -----
`timescale 1ns / 1ps
`include "crc16_framed_packet_receiver_assert.svh"

module cfpr_checker (
	input logic clk,
	input logic arst_n,
	input logic rx_ready,
	input logic res_valid,
	input logic res_ready,
	input logic [1:0] res_status,
	input logic [6:0] res_length,
	input logic [5:0] res_index,
	input logic res_has,
	input logic res_last
);

	import cfpr_pkg::*;

	`CFPR_ASSERT_NOW(a_status_ends_run, clk, arst_n, res_valid && !res_has, res_last)
	`CFPR_ASSERT_NOW(a_error_no_payload, clk, arst_n, res_valid && res_status != ST_GOOD, !res_has)
	`CFPR_ASSERT_NOW(a_index_in_frame, clk, arst_n, res_valid && res_has, res_length > 7'(res_index))
	`CFPR_ASSERT_NOW(a_no_rx_while_pending, clk, arst_n, res_valid, !rx_ready)
	`CFPR_ASSERT_NEXT(a_res_held, clk, arst_n, res_valid && !res_ready, res_valid)

endmodule

bind crc16_framed_packet_receiver cfpr_checker u_cfpr_checker (
	.clk(clk),
	.arst_n(arst_n),
	.rx_ready(rx.ready),
	.res_valid(res.valid),
	.res_ready(res.ready),
	.res_status(res.frame_status),
	.res_length(res.frame_length),
	.res_index(res.byte_index),
	.res_has(res.has_payload),
	.res_last(res.end_of_run)
);
